FILE: rtl/tcrf_pkg.sv
package tcrf_pkg;

   // One screen cell: character in the high byte, attribute in the low byte
   typedef struct packed {
      logic [7:0] glyph;
      logic [7:0] attr;
   } cell_type;

   // Operation codes carried by a request
   localparam logic [2:0] FUNC_CLEAR = 3'd0;
   localparam logic [2:0] FUNC_FILL  = 3'd1;
   localparam logic [2:0] FUNC_FRAME = 3'd2;
   localparam logic [2:0] FUNC_PUT   = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   // Register indexes of the control port
   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_BLANK   = 2'd2;

   // Character codes
   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] DASH_CODE  = 8'h2D;
   localparam logic [7:0] BAR_CODE   = 8'h7C;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   // Register reset values
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [5:0] ROWS_RESET    = 6'd25;

   // Width of the signed working rectangle during clipping
   localparam int WK_W = 14;

endpackage

FILE: rtl/tcrf_cell_store.sv
module tcrf_cell_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     addr,
   input  tcrf_pkg::cell_type    wr_cell,
   output tcrf_pkg::cell_type    rd_cell
);
   import tcrf_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_cell_ff;

   // Single port: write when enabled, read always registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_cell;
      end
      rd_cell_ff <= mem[addr];
   end

   assign rd_cell = rd_cell_ff;

endmodule

FILE: rtl/text_cell_rect_fill_engine.sv
// Character-cell screen store with clipped rectangle fill.
//
// Requests arrive on req_* (valid/stall); each gives exactly one response on
// rsp_* (valid/stall). Registers are written through csr_we/csr_index/
// csr_wdata; the user must write them only while no request is in flight, as
// the block itself does not enforce it. All work goes through one clip unit
// and one write/read port of the cell memory, one cell per cycle. Each
// rectangle pass goes through the load, clip A, clip B and setup states, then
// sweeps the cells it writes: clear and fill are a single full pass; a frame
// runs a dirty-only full pass, then top, bottom, left and right edge passes;
// put_char is a single-cell pass; a read fetches the cell from the store, or
// answers without a store read outside the area; unused operations go
// straight to the hand-over. The sequencer takes one request at a time and
// takes no new one before the last is done; req_stall stays high until the
// response is in the output register. A new request can be taken while that
// response is still held by a stalled receiver; it then waits for the output register at its end.
//
// Reset: a clearing pass writes every cell to space with attribute 7, one
// cell a cycle, all MAX_ROWS*MAX_COLUMNS cells (4096 by default). Requests are
// stalled during it; register writes are taken.
module text_cell_rect_fill_engine #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic signed [11:0] req_left,
   input  logic signed [11:0] req_top,
   input  logic signed [11:0] req_width,
   input  logic signed [11:0] req_height,
   input  logic [7:0]         req_glyph,
   input  logic [7:0]         req_color,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_dirty_left,
   output logic [10:0]        rsp_dirty_top,
   output logic [7:0]         rsp_dirty_width,
   output logic [5:0]         rsp_dirty_height,
   output logic [7:0]         rsp_read_glyph,
   output logic [7:0]         rsp_read_color,
   // control registers
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import tcrf_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_LOAD, ST_CLIPA, ST_CLIPB, ST_SETUP,
      ST_READ, ST_READ_WAIT, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PASS_FULL, PASS_TOP, PASS_BOT, PASS_LEFT, PASS_RIGHT, PASS_CELL
   } pass_type;

   // control registers
   logic [7:0] columns_ff, columns_in;
   logic [5:0] rows_ff, rows_in;
   logic [7:0] blank_ff, blank_in;

   // sequencer
   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;
   logic      init_ff, init_in;

   // latched request
   logic [2:0]         func_ff, func_in;
   logic signed [11:0] left_ff, left_in;
   logic signed [11:0] top_ff, top_in;
   logic signed [11:0] width_ff, width_in;
   logic signed [11:0] height_ff, height_in;
   logic [7:0]         glyph_ff, glyph_in;
   logic [7:0]         color_ff, color_in;

   // working rectangle of the clip unit
   logic signed [WK_W-1:0] rx_ff, rx_in;
   logic signed [WK_W-1:0] ry_ff, ry_in;
   logic signed [WK_W-1:0] rw_ff, rw_in;
   logic signed [WK_W-1:0] rh_ff, rh_in;

   // sweep counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] col_first_ff, col_first_in;
   logic [COL_W-1:0] col_last_ff, col_last_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] row_last_ff, row_last_in;
   cell_type         wr_cell_ff, wr_cell_in;

   // result being built and output register
   logic [10:0] dirty_left_ff, dirty_left_in;
   logic [10:0] dirty_top_ff, dirty_top_in;
   logic [7:0]  dirty_width_ff, dirty_width_in;
   logic [5:0]  dirty_height_ff, dirty_height_in;
   logic [7:0]  read_glyph_ff, read_glyph_in;
   logic [7:0]  read_color_ff, read_color_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_left_ff, rsp_left_in;
   logic [10:0] rsp_top_ff, rsp_top_in;
   logic [7:0]  rsp_width_ff, rsp_width_in;
   logic [5:0]  rsp_height_ff, rsp_height_in;
   logic [7:0]  rsp_glyph_ff, rsp_glyph_in;
   logic [7:0]  rsp_color_ff, rsp_color_in;

   // combinational helpers
   logic signed [WK_W-1:0] cols_eff, rows_eff;
   logic signed [WK_W-1:0] sl, st, sw, sh;
   logic signed [WK_W-1:0] dx, dy, wt, ht;
   logic signed [WK_W-1:0] col_end, row_end;
   logic [8:0]             cols_raw;
   logic [7:0]             rows_raw;
   logic                   more_passes;
   pass_type               pass_next;
   logic                   pass_writes;
   logic                   pass_captures;
   logic                   read_outside;
   logic                   out_free;
   logic                   mem_we;
   logic [ROW_W-1:0]       addr_row;
   logic [COL_W-1:0]       addr_col;
   logic [ADDR_W-1:0]      mem_addr;
   cell_type               rd_cell;

   // clamp area registers to the store size
   always_comb begin
      cols_raw = {1'b0, columns_ff};
      rows_raw = {2'b00, rows_ff};
      if (cols_raw > 9'(MAX_COLUMNS)) begin
         cols_eff = WK_W'(MAX_COLUMNS);
      end else begin
         cols_eff = WK_W'(cols_raw);
      end
      if (rows_raw > 8'(MAX_ROWS)) begin
         rows_eff = WK_W'(MAX_ROWS);
      end else begin
         rows_eff = WK_W'(rows_raw);
      end
   end

   // widen request fields
   assign sl = WK_W'(left_ff);
   assign st = WK_W'(top_ff);
   assign sw = WK_W'(width_ff);
   assign sh = WK_W'(height_ff);

   // right and bottom cut of the clip unit
   assign dx = cols_eff - rx_ff;
   assign dy = rows_eff - ry_ff;
   assign wt = (rw_ff > dx) ? dx : rw_ff;
   assign ht = (rh_ff > dy) ? dy : rh_ff;

   // last column and row of a clipped, non-empty rectangle
   assign col_end = rx_ff + rw_ff - WK_W'(1);
   assign row_end = ry_ff + rh_ff - WK_W'(1);

   // pass order: frame walks full (dirty only), top, bottom, left, right
   always_comb begin
      more_passes   = (func_ff == FUNC_FRAME) && (pass_ff != PASS_RIGHT);
      pass_writes   = !((func_ff == FUNC_FRAME) && (pass_ff == PASS_FULL));
      pass_captures = (pass_ff == PASS_FULL) || (pass_ff == PASS_CELL);
      case (pass_ff)
         PASS_FULL: pass_next = PASS_TOP;
         PASS_TOP:  pass_next = PASS_BOT;
         PASS_BOT:  pass_next = PASS_LEFT;
         default:   pass_next = PASS_RIGHT;
      endcase
   end

   assign read_outside = (sl < 0) || (st < 0) || (sl >= cols_eff) || (st >= rows_eff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // memory port: sweep position, or the read target
   assign mem_we   = (state_ff == ST_SWEEP);
   assign addr_row = (state_ff == ST_READ) ? top_ff[ROW_W-1:0] : row_ff;
   assign addr_col = (state_ff == ST_READ) ? left_ff[COL_W-1:0] : col_ff;
   assign mem_addr = ADDR_W'(addr_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(addr_col);

   tcrf_cell_store #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_cell (wr_cell_ff),
      .rd_cell (rd_cell)
   );

   // next-state logic
   always_comb begin
      columns_in      = columns_ff;
      rows_in         = rows_ff;
      blank_in        = blank_ff;
      state_in        = state_ff;
      pass_in         = pass_ff;
      init_in         = init_ff;
      func_in         = func_ff;
      left_in         = left_ff;
      top_in          = top_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      glyph_in        = glyph_ff;
      color_in        = color_ff;
      rx_in           = rx_ff;
      ry_in           = ry_ff;
      rw_in           = rw_ff;
      rh_in           = rh_ff;
      col_in          = col_ff;
      col_first_in    = col_first_ff;
      col_last_in     = col_last_ff;
      row_in          = row_ff;
      row_last_in     = row_last_ff;
      wr_cell_in      = wr_cell_ff;
      dirty_left_in   = dirty_left_ff;
      dirty_top_in    = dirty_top_ff;
      dirty_width_in  = dirty_width_ff;
      dirty_height_in = dirty_height_ff;
      read_glyph_in   = read_glyph_ff;
      read_color_in   = read_color_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_width_in    = rsp_width_ff;
      rsp_height_in   = rsp_height_ff;
      rsp_glyph_in    = rsp_glyph_ff;
      rsp_color_in    = rsp_color_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS: columns_in = csr_wdata;
            CSR_ROWS:    rows_in    = csr_wdata[5:0];
            CSR_BLANK:   blank_in   = csr_wdata;
            default:     ;
         endcase
      end

      // drop a response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in         = req_func;
               left_in         = req_left;
               top_in          = req_top;
               width_in        = req_width;
               height_in       = req_height;
               glyph_in        = req_glyph;
               color_in        = req_color;
               dirty_left_in   = '0;
               dirty_top_in    = '0;
               dirty_width_in  = '0;
               dirty_height_in = '0;
               read_glyph_in   = '0;
               read_color_in   = '0;
               unique case (req_func) inside
                  FUNC_CLEAR, FUNC_FILL, FUNC_FRAME: begin
                     pass_in  = PASS_FULL;
                     state_in = ST_LOAD;
                  end
                  FUNC_PUT: begin
                     pass_in  = PASS_CELL;
                     state_in = ST_LOAD;
                  end
                  FUNC_READ: state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end

         // load the raw rectangle of this pass
         ST_LOAD: begin
            rx_in = sl;
            ry_in = st;
            rw_in = sw;
            rh_in = sh;
            wr_cell_in = '{glyph: glyph_ff, attr: color_ff};
            unique case (pass_ff)
               PASS_FULL: begin
                  if (func_ff == FUNC_CLEAR) begin
                     rx_in = '0;
                     ry_in = '0;
                     rw_in = cols_eff;
                     rh_in = rows_eff;
                     wr_cell_in = '{glyph: SPACE_CODE, attr: blank_ff};
                  end
               end
               PASS_TOP: begin
                  rh_in = WK_W'(1);
                  wr_cell_in.glyph = DASH_CODE;
               end
               PASS_BOT: begin
                  ry_in = st + sh - WK_W'(1);
                  rh_in = WK_W'(1);
                  wr_cell_in.glyph = DASH_CODE;
               end
               PASS_LEFT: begin
                  rw_in = WK_W'(1);
                  wr_cell_in.glyph = BAR_CODE;
               end
               PASS_RIGHT: begin
                  rx_in = sl + sw - WK_W'(1);
                  rw_in = WK_W'(1);
                  wr_cell_in.glyph = BAR_CODE;
               end
               PASS_CELL: begin
                  rw_in = WK_W'(1);
                  rh_in = WK_W'(1);
               end
               default: ;
            endcase
            state_in = ST_CLIPA;
         end

         // move a negative origin to zero, shortening the extent
         ST_CLIPA: begin
            if (rx_ff < 0) begin
               rw_in = rw_ff + rx_ff;
               rx_in = '0;
            end
            if (ry_ff < 0) begin
               rh_in = rh_ff + ry_ff;
               ry_in = '0;
            end
            state_in = ST_CLIPB;
         end

         // cut at the area edge, force negative extents to zero
         ST_CLIPB: begin
            rw_in    = (wt < 0) ? '0 : wt;
            rh_in    = (ht < 0) ? '0 : ht;
            state_in = ST_SETUP;
         end

         // record the dirty rectangle and arm the sweep
         ST_SETUP: begin
            if (pass_captures) begin
               dirty_left_in   = rx_ff[10:0];
               dirty_top_in    = ry_ff[10:0];
               dirty_width_in  = rw_ff[7:0];
               dirty_height_in = rh_ff[5:0];
            end
            col_first_in = rx_ff[COL_W-1:0];
            col_in       = rx_ff[COL_W-1:0];
            col_last_in  = col_end[COL_W-1:0];
            row_in       = ry_ff[ROW_W-1:0];
            row_last_in  = row_end[ROW_W-1:0];
            if (pass_writes && (rw_ff != 0) && (rh_ff != 0)) begin
               state_in = ST_SWEEP;
            end else if (more_passes) begin
               pass_in  = pass_next;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end

         // write one cell a cycle, row by row
         ST_SWEEP: begin
            if (col_ff == col_last_ff) begin
               col_in = col_first_ff;
               if (row_ff == row_last_ff) begin
                  if (init_ff) begin
                     init_in  = 1'b0;
                     state_in = ST_IDLE;
                  end else if (more_passes) begin
                     pass_in  = pass_next;
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end

         ST_READ: begin
            if (read_outside) begin
               read_glyph_in = SPACE_CODE;
               read_color_in = blank_ff;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_READ_WAIT;
            end
         end

         ST_READ_WAIT: begin
            read_glyph_in = rd_cell.glyph;
            read_color_in = rd_cell.attr;
            state_in      = ST_DONE;
         end

         // hand the result to the output register when it is free
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_left_in   = dirty_left_ff;
               rsp_top_in    = dirty_top_ff;
               rsp_width_in  = dirty_width_ff;
               rsp_height_in = dirty_height_ff;
               rsp_glyph_in  = read_glyph_ff;
               rsp_color_in  = read_color_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         blank_ff     <= RESET_ATTR;
         state_ff     <= ST_SWEEP;
         pass_ff      <= PASS_FULL;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         col_first_ff <= '0;
         col_last_ff  <= COL_W'(MAX_COLUMNS - 1);
         row_ff       <= '0;
         row_last_ff  <= ROW_W'(MAX_ROWS - 1);
         wr_cell_ff   <= '{glyph: SPACE_CODE, attr: RESET_ATTR};
      end else begin
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         blank_ff     <= blank_in;
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         col_first_ff <= col_first_in;
         col_last_ff  <= col_last_in;
         row_ff       <= row_in;
         row_last_ff  <= row_last_in;
         wr_cell_ff   <= wr_cell_in;
      end
      func_ff         <= func_in;
      left_ff         <= left_in;
      top_ff          <= top_in;
      width_ff        <= width_in;
      height_ff       <= height_in;
      glyph_ff        <= glyph_in;
      color_ff        <= color_in;
      rx_ff           <= rx_in;
      ry_ff           <= ry_in;
      rw_ff           <= rw_in;
      rh_ff           <= rh_in;
      dirty_left_ff   <= dirty_left_in;
      dirty_top_ff    <= dirty_top_in;
      dirty_width_ff  <= dirty_width_in;
      dirty_height_ff <= dirty_height_in;
      read_glyph_ff   <= read_glyph_in;
      read_color_ff   <= read_color_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_top_ff      <= rsp_top_in;
      rsp_width_ff    <= rsp_width_in;
      rsp_height_ff   <= rsp_height_in;
      rsp_glyph_ff    <= rsp_glyph_in;
      rsp_color_ff    <= rsp_color_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dirty_left   = rsp_left_ff;
   assign rsp_dirty_top    = rsp_top_ff;
   assign rsp_dirty_width  = rsp_width_ff;
   assign rsp_dirty_height = rsp_height_ff;
   assign rsp_read_glyph   = rsp_glyph_ff;
   assign rsp_read_color   = rsp_color_ff;

   // a new response only comes out of the hand-over state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside hand-over");

   // no request taken during the clearing pass
   a_init_stalls: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> req_stall)
      else $error("request accepted during clearing pass");

   // sweep column stays inside its clipped span
   a_sweep_cols: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (col_ff >= col_first_ff) && (col_ff <= col_last_ff))
      else $error("sweep column out of span");

   // command writes stay inside the used area
   a_sweep_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) && !init_ff |->
         (WK_W'(row_ff) < rows_eff) && (WK_W'(col_ff) < cols_eff))
      else $error("write outside used area");

endmodule

FILE: tb/sv/text_cell_rect_fill_engine_tb.sv
module text_cell_rect_fill_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcrf_pkg::*;

   localparam int SCREEN_COLS = 128;
   localparam int SCREEN_ROWS = 32;
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0]         func;
      logic signed [11:0] left;
      logic signed [11:0] top;
      logic signed [11:0] width;
      logic signed [11:0] height;
      logic [7:0]         glyph;
      logic [7:0]         color;
   } command_type;

   typedef struct packed {
      logic [10:0] dirty_left;
      logic [10:0] dirty_top;
      logic [7:0]  dirty_width;
      logic [5:0]  dirty_height;
      logic [7:0]  read_glyph;
      logic [7:0]  read_color;
   } outcome_type;

   typedef struct {
      int x;
      int y;
      int w;
      int h;
   } box_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_func = '0;
   logic signed [11:0] req_left = '0;
   logic signed [11:0] req_top = '0;
   logic signed [11:0] req_width = '0;
   logic signed [11:0] req_height = '0;
   logic [7:0]         req_glyph = '0;
   logic [7:0]         req_color = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [10:0]        rsp_dirty_left;
   logic [10:0]        rsp_dirty_top;
   logic [7:0]         rsp_dirty_width;
   logic [5:0]         rsp_dirty_height;
   logic [7:0]         rsp_read_glyph;
   logic [7:0]         rsp_read_color;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [7:0]         csr_wdata = '0;

   // Predicted screen contents and register copies
   cell_type   screen_model [SCREEN_COLS*SCREEN_ROWS];
   logic [7:0] model_cols;
   logic [5:0] model_rows;
   logic [7:0] model_blank;

   outcome_type pending_results [$];
   int          fail_count = 0;
   int          hold_cycles = 0;
   bit          quiet_tail = 1'b0;

   text_cell_rect_fill_engine #(
      .MAX_COLUMNS(SCREEN_COLS),
      .MAX_ROWS   (SCREEN_ROWS)
   ) u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int area_cols();
      return (model_cols > SCREEN_COLS) ? SCREEN_COLS : int'(model_cols);
   endfunction

   function automatic int area_rows();
      return (model_rows > SCREEN_ROWS) ? SCREEN_ROWS : int'(model_rows);
   endfunction

   // Cut a rectangle to the used area; empty extents become zero
   function automatic box_type clip_box(int x, int y, int w, int h);
      box_type b;
      int      c;
      int      r;
      c = area_cols();
      r = area_rows();
      if (x < 0) begin
         w = w + x;
         x = 0;
      end
      if (y < 0) begin
         h = h + y;
         y = 0;
      end
      if (x + w > c) w = c - x;
      if (y + h > r) h = r - y;
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      b.x = x;
      b.y = y;
      b.w = w;
      b.h = h;
      return b;
   endfunction

   function automatic void paint(int x, int y, int w, int h,
                                 logic [7:0] g, logic [7:0] a);
      box_type b;
      b = clip_box(x, y, w, h);
      for (int row = b.y; row < b.y + b.h; row++)
         for (int col = b.x; col < b.x + b.w; col++)
            screen_model[row*SCREEN_COLS + col] = '{glyph: g, attr: a};
   endfunction

   function automatic void reset_model();
      model_cols  = COLUMNS_RESET;
      model_rows  = ROWS_RESET;
      model_blank = RESET_ATTR;
      foreach (screen_model[i]) screen_model[i] = '{glyph: SPACE_CODE, attr: RESET_ATTR};
   endfunction

   // Update the screen for one request and work out its response
   function automatic outcome_type apply_command(command_type cmd);
      outcome_type res;
      box_type     d;
      int          x;
      int          y;
      int          w;
      int          h;
      res = '0;
      d   = '{0, 0, 0, 0};
      x   = cmd.left;
      y   = cmd.top;
      w   = cmd.width;
      h   = cmd.height;
      case (cmd.func)
         FUNC_CLEAR: begin
            paint(0, 0, area_cols(), area_rows(), SPACE_CODE, model_blank);
            d = clip_box(0, 0, area_cols(), area_rows());
         end
         FUNC_FILL: begin
            paint(x, y, w, h, cmd.glyph, cmd.color);
            d = clip_box(x, y, w, h);
         end
         FUNC_FRAME: begin
            // dashes first, bars last so that bars win at the corners
            paint(x, y, w, 1, DASH_CODE, cmd.color);
            paint(x, y + h - 1, w, 1, DASH_CODE, cmd.color);
            paint(x, y, 1, h, BAR_CODE, cmd.color);
            paint(x + w - 1, y, 1, h, BAR_CODE, cmd.color);
            d = clip_box(x, y, w, h);
         end
         FUNC_PUT: begin
            paint(x, y, 1, 1, cmd.glyph, cmd.color);
            d = clip_box(x, y, 1, 1);
         end
         FUNC_READ: begin
            if (x < 0 || y < 0 || x >= area_cols() || y >= area_rows()) begin
               res.read_glyph = SPACE_CODE;
               res.read_color = model_blank;
            end else begin
               res.read_glyph = screen_model[y*SCREEN_COLS + x].glyph;
               res.read_color = screen_model[y*SCREEN_COLS + x].attr;
            end
         end
         default: ;
      endcase
      res.dirty_left   = 11'(d.x);
      res.dirty_top    = 11'(d.y);
      res.dirty_width  = 8'(d.w);
      res.dirty_height = 6'(d.h);
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one request, hold it until taken, then record its response
   task automatic send_command(logic [2:0] f, int l, int t, int w, int h,
                               logic [7:0] g, logic [7:0] c);
      command_type cmd;
      int          gap;
      cmd.func   = f;
      cmd.left   = 12'(l);
      cmd.top    = 12'(t);
      cmd.width  = 12'(w);
      cmd.height = 12'(h);
      cmd.glyph  = g;
      cmd.color  = c;
      gap = (quiet_tail || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= cmd.func;
      req_left   <= cmd.left;
      req_top    <= cmd.top;
      req_width  <= cmd.width;
      req_height <= cmd.height;
      req_glyph  <= cmd.glyph;
      req_color  <= cmd.color;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_command(cmd));
   endtask

   // Drop valid and wait for every outstanding response
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COLUMNS: model_cols  = value;
         CSR_ROWS:    model_rows  = value[5:0];
         CSR_BLANK:   model_blank = value;
         default: ;
      endcase
   endtask

   task automatic set_area(logic [7:0] cols, logic [7:0] rows, logic [7:0] blank);
      drain_responses();
      write_register(CSR_COLUMNS, cols);
      write_register(CSR_ROWS, rows);
      write_register(CSR_BLANK, blank);
   endtask

   // Mostly near the area's edges, now and then anywhere in the 12-bit range
   function automatic int pick_coord(int limit);
      if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 4095)) - 2048;
      return int'($urandom_range(0, limit + 7)) - 4;
   endfunction

   function automatic int pick_extent(int limit);
      int span;
      span = (limit < 14) ? limit : 14;
      if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 4095)) - 2048;
      return int'($urandom_range(0, span + 3)) - 2;
   endfunction

   task automatic send_random_command();
      logic [2:0] f;
      int         sel;
      int         c;
      int         r;
      c   = area_cols();
      r   = area_rows();
      sel = $urandom_range(0, 99);
      if (sel < 4)       f = FUNC_CLEAR;
      else if (sel < 29) f = FUNC_FILL;
      else if (sel < 44) f = FUNC_FRAME;
      else if (sel < 69) f = FUNC_PUT;
      else if (sel < 95) f = FUNC_READ;
      else               f = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      send_command(f, pick_coord(c), pick_coord(r), pick_extent(c), pick_extent(r),
                   8'($urandom), 8'($urandom));
   endtask

   // Receiver idling: long hold-off on request, else short random bursts
   initial begin : receiver_idling
      int burst;
      int calm;
      burst = 0;
      calm  = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (quiet_tail || calm > 0) begin
            rsp_stall <= 1'b0;
            if (calm > 0) calm--;
         end else if ($urandom_range(0, 49) == 0) begin
            rsp_stall <= 1'b0;
            calm = $urandom_range(20, 80);
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_dirty_left, rsp_dirty_top, rsp_dirty_width, rsp_dirty_height,
                  rsp_read_glyph, rsp_read_color};
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: response with no request outstanding: %p", $realtime, seen);
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response mismatch", $realtime);
                  $display("  expected left %0d top %0d w %0d h %0d glyph %h color %h",
                           want.dirty_left, want.dirty_top, want.dirty_width,
                           want.dirty_height, want.read_glyph, want.read_color);
                  $display("  actual   left %0d top %0d w %0d h %0d glyph %h color %h",
                           seen.dirty_left, seen.dirty_top, seen.dirty_width,
                           seen.dirty_height, seen.read_glyph, seen.read_color);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Screen straight after the clearing pass, plus an unused operation code
   task automatic test_power_on_state();
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 79, 24, 0, 0, 8'hFF, 8'hFF);
      send_command(FUNC_READ, -1, 5, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_SPARE_LAST, -2048, 2047, -2048, 2047, 8'hFF, 8'hFF);
   endtask

   task automatic test_operations();
      // single cells, glyph zero included, one outside the area
      send_command(FUNC_PUT, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_PUT, 79, 24, 0, 0, 8'hFF, 8'hFF);
      send_command(FUNC_PUT, 80, 24, 0, 0, 8'h41, 8'h1E);
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 79, 24, 0, 0, 8'h00, 8'h00);
      // fills: negative origin eats the extent, oversized extent, negative width
      send_command(FUNC_FILL, -2048, -2048, 2047, 2047, 8'h41, 8'h1E);
      send_command(FUNC_FILL, 3, 2, 2047, 2047, 8'h42, 8'h2F);
      send_command(FUNC_FILL, 5, 5, -3, 4, 8'h43, 8'h30);
      // frames: normal, zero width, negative height, off the corner, one cell
      send_command(FUNC_FRAME, 2, 2, 10, 5, 8'h00, 8'h4E);
      send_command(FUNC_FRAME, 20, 3, 0, 4, 8'h00, 8'h5A);
      send_command(FUNC_FRAME, 30, 10, 6, -2, 8'h00, 8'h61);
      send_command(FUNC_FRAME, -3, -2, 8, 6, 8'h00, 8'h72);
      send_command(FUNC_FRAME, 78, 23, 1, 1, 8'h00, 8'h83);
      send_command(FUNC_READ, 2, 2, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 5, 2, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 19, 4, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 2047, -2048, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_CLEAR, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 10, 10, 0, 0, 8'h00, 8'h00);
   endtask

   task automatic test_area_extremes();
      // full store
      set_area(8'd128, 8'd32, 8'hFF);
      send_command(FUNC_CLEAR, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_FILL, 120, 28, 2047, 2047, 8'h5F, 8'h11);
      send_command(FUNC_READ, 127, 31, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 128, 31, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
      // oversized registers act as the store size
      set_area(8'hFF, 8'hFF, 8'h00);
      send_command(FUNC_PUT, 127, 31, 0, 0, 8'hA5, 8'h5A);
      send_command(FUNC_READ, 127, 31, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 128, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_FRAME, -1, -1, 130, 34, 8'h00, 8'h3C);
      // one-cell area
      set_area(8'd1, 8'd1, 8'h80);
      send_command(FUNC_FILL, 0, 0, 5, 5, 8'h23, 8'h44);
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 1, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_CLEAR, 0, 0, 0, 0, 8'h00, 8'h00);
      // empty area: nothing written, every read outside
      set_area(8'd0, 8'd5, 8'h55);
      send_command(FUNC_FILL, 0, 0, 4, 4, 8'h24, 8'h66);
      send_command(FUNC_CLEAR, 0, 0, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
      set_area(8'd10, 8'd0, 8'hAA);
      send_command(FUNC_PUT, 0, 0, 0, 0, 8'h25, 8'h77);
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
      // cells keep their address across area changes
      set_area(8'd128, 8'd32, 8'h07);
      send_command(FUNC_READ, 127, 31, 0, 0, 8'h00, 8'h00);
      send_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00);
   endtask

   // Hold the receiver off so that the block fills up and stalls requests
   task automatic test_stalled_receiver();
      drain_responses();
      hold_cycles = 400;
      repeat (8) send_random_command();
      drain_responses();
   endtask

   task automatic test_random_mix();
      int         pick;
      logic [7:0] cols;
      logic [7:0] rows;
      for (int phase = 0; phase < 10; phase++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               cols = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 20));
               rows = (cols == 8'd0) ? 8'($urandom_range(1, 10)) : 8'd0;
            end
            1: begin
               cols = 8'hFF;
               rows = 8'hFF;
            end
            2: begin
               cols = 8'd128;
               rows = 8'd32;
            end
            3: begin
               cols = 8'd80;
               rows = 8'd25;
            end
            default: begin
               cols = 8'($urandom_range(1, 24));
               rows = {2'($urandom), 6'($urandom_range(1, 10))};
            end
         endcase
         set_area(cols, rows, 8'($urandom));
         repeat (60) send_random_command();
      end
   endtask

   task automatic test_quiet_tail();
      quiet_tail = 1'b1;
      repeat (60) send_random_command();
   endtask

   task automatic finish_run();
      drain_responses();
      repeat (50) @(posedge clock);
      fail_count += pending_results.size();
      if (fail_count == 0) begin
         $display("text_cell_rect_fill_engine test passed");
      end else begin
         $display("text_cell_rect_fill_engine test failed");
      end
      $finish;
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_power_on_state();
      test_operations();
      test_area_extremes();
      test_stalled_receiver();
      test_random_mix();
      test_quiet_tail();
      finish_run();
   end

   // Watchdog
   initial begin
      #30_000_000;
      $display("text_cell_rect_fill_engine test failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/tcrf_pkg.sv
rtl/tcrf_cell_store.sv
rtl/text_cell_rect_fill_engine.sv
tb/sv/text_cell_rect_fill_engine_tb.sv
